@@ design/dlbp_pkg.sv @@
package dlbp_pkg;

    localparam int WORD_W      = 64;
    localparam int LEN_W       = 6;
    localparam int HDR_W       = LEN_W + 1;
    localparam int REC_W       = HDR_W + WORD_W - 1;
    localparam int NBITS_W     = 7;
    localparam int TOTAL_W     = 40;
    localparam int FILL_W      = 6;
    localparam int RESERVED    = 32;
    localparam int WIN_W       = 3 * WORD_W;
    localparam int SUM_W       = 8;
    localparam int MAX_WORDS   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DEPTH   = 4;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_INIT = TOTAL_W'(RESERVED);
    localparam logic [FILL_W-1:0]  FILL_INIT  = FILL_W'(RESERVED);

    typedef struct packed {
        logic signed [WORD_W-1:0] sample;
        logic signed [WORD_W-1:0] predicted;
        logic                     end_of_stream;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0]  packed_word;
        logic               final_word;
        logic [TOTAL_W-1:0] bits_used;
    } t_out;

    // One classified request: length prefix, sign and payload, right-aligned.
    typedef struct packed {
        logic [REC_W-1:0]   bits;
        logic [NBITS_W-1:0] nbits;
        logic               eos;
    } t_rec;

endpackage

@@ design/dlbp_front.sv @@
module dlbp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  dlbp_pkg::t_in i_item,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output dlbp_pkg::t_rec o_q_data
);

    logic                          r_vld;
    logic [dlbp_pkg::WORD_W-1:0]   r_diff;
    logic                          r_eos;
    logic                          advance;
    logic                          accept;
    logic                          sign;
    logic [dlbp_pkg::WORD_W-1:0]   mag;
    logic [dlbp_pkg::LEN_W-1:0]    len;
    logic [dlbp_pkg::WORD_W-1:0]   mask;
    logic [dlbp_pkg::REC_W-1:0]    hdr;

    assign advance = !r_vld || !i_q_full;
    assign full    = !advance;
    assign accept  = push && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (advance) begin
            r_vld <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff <= i_item.sample - i_item.predicted;
            r_eos  <= i_item.end_of_stream;
        end
    end

    // Length is one past the highest bit that differs from the sign.
    always_comb begin
        sign = r_diff[dlbp_pkg::WORD_W-1];
        mag  = sign ? ~r_diff : r_diff;
        len  = '0;
        for (int i = 0; i < dlbp_pkg::WORD_W - 1; i++) begin
            if (mag[i]) begin
                len = dlbp_pkg::LEN_W'(i + 1);
            end
        end
    end

    assign mask = (dlbp_pkg::WORD_W'(1) << len) - dlbp_pkg::WORD_W'(1);
    assign hdr  = {{(dlbp_pkg::REC_W - dlbp_pkg::HDR_W){1'b0}}, len, sign};

    assign o_q_wr         = r_vld && !i_q_full;
    assign o_q_data.bits  = (hdr << len)
                          | {{(dlbp_pkg::REC_W - dlbp_pkg::WORD_W){1'b0}}, r_diff & mask};
    assign o_q_data.nbits = dlbp_pkg::NBITS_W'(dlbp_pkg::HDR_W) + {1'b0, len};
    assign o_q_data.eos   = r_eos;

endmodule

@@ design/dlbp_queue.sv @@
module dlbp_queue #(
    parameter int DEPTH = dlbp_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dlbp_pkg::t_rec i_wdata,
    output logic           o_full,
    input  logic           i_rd,
    output dlbp_pkg::t_rec o_rdata,
    output logic           o_empty
);

    // DEPTH must be a power of two so that the pointers wrap on their own.
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dlbp_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt + CW'(i_wr) - CW'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= r_wr + PW'(1);
            end
            if (i_rd) begin
                r_rd <= r_rd + PW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("write into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("read from an empty queue");

endmodule

@@ design/dlbp_back.sv @@
module dlbp_back #(
    parameter int OUT_DEPTH = dlbp_pkg::OUT_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dlbp_pkg::t_rec i_rec,
    input  logic           i_q_empty,
    output logic           o_q_rd,
    output logic           empty,
    input  logic           pop,
    output dlbp_pkg::t_out o_result
);

    // OUT_DEPTH must be a power of two and at least three.
    localparam int OW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam int WW = dlbp_pkg::WORD_W;
    localparam int TW = dlbp_pkg::TOTAL_W;
    localparam int SW = dlbp_pkg::SUM_W;

    dlbp_pkg::t_out         r_buf [OUT_DEPTH];
    logic [OW-1:0]          r_wr;
    logic [OW-1:0]          r_rd;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          n_cnt;
    logic [WW-1:0]          r_pend;
    logic [WW-1:0]          n_pend;
    logic [dlbp_pkg::FILL_W-1:0] r_fill;
    logic [TW-1:0]          r_total;
    logic [TW-1:0]          n_total;

    logic [SW-1:0]          sum;
    logic [SW-1:0]          sh;
    logic [dlbp_pkg::WIN_W-1:0] win;
    logic [WW-1:0]          words [dlbp_pkg::MAX_WORDS];
    logic [1:0]             full_cnt;
    logic [1:0]             nw;
    logic [CW-1:0]          free;
    logic                   take;
    logic                   pop_ok;
    dlbp_pkg::t_out         wdata [dlbp_pkg::MAX_WORDS];
    logic [OW-1:0]          widx  [dlbp_pkg::MAX_WORDS];
    logic                   wen   [dlbp_pkg::MAX_WORDS];

    // Place the request just after the filled bits of the pending word.
    assign sum = SW'(r_fill) + SW'(i_rec.nbits);
    assign sh  = SW'(dlbp_pkg::WIN_W) - sum;
    assign win = {r_pend, {(dlbp_pkg::WIN_W - WW){1'b0}}}
               | ({{(dlbp_pkg::WIN_W - dlbp_pkg::REC_W){1'b0}}, i_rec.bits} << sh);

    assign words[0] = win[3*WW-1:2*WW];
    assign words[1] = win[2*WW-1:WW];
    assign words[2] = win[WW-1:0];

    assign full_cnt = sum[SW-1:SW-2];
    assign nw       = full_cnt + {1'b0, i_rec.eos};
    assign free     = CW'(OUT_DEPTH) - r_cnt;
    assign take     = !i_q_empty && (CW'(nw) <= free);
    assign o_q_rd   = take;
    assign pop_ok   = pop && (r_cnt != '0);

    assign n_pend = words[full_cnt];

    // Saturate the running bit count.
    always_comb begin
        if (r_total > dlbp_pkg::TOTAL_MAX - TW'(i_rec.nbits)) begin
            n_total = dlbp_pkg::TOTAL_MAX;
        end else begin
            n_total = r_total + TW'(i_rec.nbits);
        end
    end

    // Filled words first, then the flushed word when the stream ends.
    always_comb begin
        for (int k = 0; k < dlbp_pkg::MAX_WORDS; k++) begin
            widx[k] = r_wr + OW'(k);
            wen[k]  = take && (2'(k) < nw);
            if (2'(k) < full_cnt) begin
                wdata[k].packed_word = words[k];
                wdata[k].final_word  = 1'b0;
                wdata[k].bits_used   = '0;
            end else begin
                wdata[k].packed_word = n_pend;
                wdata[k].final_word  = 1'b1;
                wdata[k].bits_used   = n_total;
            end
        end
        n_cnt = r_cnt + (take ? CW'(nw) : CW'(0)) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_pend  <= '0;
            r_fill  <= dlbp_pkg::FILL_INIT;
            r_total <= dlbp_pkg::TOTAL_INIT;
        end else begin
            r_cnt <= n_cnt;
            if (pop_ok) begin
                r_rd <= r_rd + OW'(1);
            end
            if (take) begin
                r_wr <= r_wr + OW'(nw);
                if (i_rec.eos) begin
                    r_pend  <= '0;
                    r_fill  <= dlbp_pkg::FILL_INIT;
                    r_total <= dlbp_pkg::TOTAL_INIT;
                end else begin
                    r_pend  <= n_pend;
                    r_fill  <= sum[dlbp_pkg::FILL_W-1:0];
                    r_total <= n_total;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < dlbp_pkg::MAX_WORDS; k++) begin
            if (wen[k]) begin
                r_buf[widx[k]] <= wdata[k];
            end
        end
    end

    assign empty    = (r_cnt == '0);
    assign o_result = r_buf[r_rd];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(OUT_DEPTH))
        else $error("result buffer count beyond depth");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_rec.eos |=> r_fill == dlbp_pkg::FILL_INIT
                              && r_total == dlbp_pkg::TOTAL_INIT && r_pend == '0)
        else $error("stream state not restored after flush");

    a_total_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total >= dlbp_pkg::TOTAL_INIT)
        else $error("bit count below the reserved bits");

    a_count_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_result.final_word |-> o_result.bits_used == '0)
        else $error("bit count on a word that is not final");

endmodule

@@ design/delta_length_prefix_bit_packer.sv @@
// Delta length-prefix bit packer.
// Input queue side: drive i_item and raise push; the request is taken at a
// clock edge where push is high and full is low. Each request carries a
// sample, its prediction and an end-of-stream flag.
// Result queue side: while empty is low, o_result holds the oldest packed
// word; raise pop to take it. Filled words carry final_word low and a zero
// bit count; the word flushed by end-of-stream carries final_word high and
// the saturating total including the 32 reserved leading bits.
// Throughput: one request per cycle. The front stage forms the difference and
// its length; a two-entry queue feeds the packer, which folds one request a
// cycle into the pending word and writes up to three results into a
// four-entry result buffer. A request that needs more slots than are free
// waits in the queue, so a sustained rate of one request per cycle holds
// while each request yields at most one word and pop stays high.
// Reset (synchronous, active low) empties both queues and starts a new
// stream with 32 reserved bits. When the receiver stalls, the result buffer
// fills, the queue backs up and full rises; nothing is lost.
module delta_length_prefix_bit_packer #(
    parameter int QUEUE_DEPTH = dlbp_pkg::QUEUE_DEPTH,
    parameter int OUT_DEPTH   = dlbp_pkg::OUT_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  dlbp_pkg::t_in  i_item,
    output logic           empty,
    input  logic           pop,
    output dlbp_pkg::t_out o_result
);

    logic           q_wr;
    logic           q_full;
    logic           q_rd;
    logic           q_empty;
    dlbp_pkg::t_rec q_wdata;
    dlbp_pkg::t_rec q_rdata;

    dlbp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_q_data (q_wdata)
    );

    dlbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    dlbp_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rec     (q_rdata),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

@@ dv/tb_delta_length_prefix_bit_packer.sv @@
module tb_delta_length_prefix_bit_packer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 12;
    localparam int RANDOM_REQS = 260;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    dlbp_pkg::t_in  i_item = '0;
    logic full;
    logic empty;
    dlbp_pkg::t_out o_result;

    dlbp_pkg::t_in  sample_q[$];
    dlbp_pkg::t_out packed_words_q[$];

    // Packer state mirrored on the testbench side
    logic [dlbp_pkg::WORD_W-1:0]  acc_word;
    int unsigned                  acc_fill;
    logic [dlbp_pkg::TOTAL_W-1:0] acc_total;

    int n_taken;
    int n_words;
    int n_final;
    int n_errors;
    int quiet;
    bit calm;

    delta_length_prefix_bit_packer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic void start_stream();
        acc_word  = '0;
        acc_fill  = dlbp_pkg::RESERVED;
        acc_total = dlbp_pkg::TOTAL_INIT;
    endfunction

    function automatic void expect_word(logic [dlbp_pkg::WORD_W-1:0] w, logic fin,
                                        logic [dlbp_pkg::TOTAL_W-1:0] used);
        dlbp_pkg::t_out r;
        r.packed_word = w;
        r.final_word  = fin;
        r.bits_used   = used;
        packed_words_q.push_back(r);
    endfunction

    // Place the low n bits of v, MSB first, emitting the word when it fills
    function automatic void append_field(logic [dlbp_pkg::WORD_W-1:0] v, int unsigned n);
        int unsigned space;
        int unsigned rem;
        if (n == 0)
            return;
        if (n < dlbp_pkg::WORD_W)
            v &= (64'd1 << n) - 64'd1;
        space = dlbp_pkg::WORD_W - acc_fill;
        if (n < space) begin
            acc_word |= v << (space - n);
            acc_fill += n;
            return;
        end
        rem = n - space;
        acc_word |= v >> rem;
        expect_word(acc_word, 1'b0, '0);
        acc_word = (rem == 0) ? '0 : v << (dlbp_pkg::WORD_W - rem);
        acc_fill = rem;
    endfunction

    function automatic void pack_sample(dlbp_pkg::t_in req);
        logic [dlbp_pkg::WORD_W-1:0]  d;
        logic [dlbp_pkg::WORD_W-1:0]  mag;
        logic [dlbp_pkg::TOTAL_W-1:0] nbits;
        int unsigned                  len;
        d   = req.sample - req.predicted;
        mag = d[dlbp_pkg::WORD_W-1] ? ~d : d;
        len = 0;
        for (int i = 0; i < dlbp_pkg::WORD_W; i++)
            if (mag[i])
                len = i + 1;
        append_field(dlbp_pkg::WORD_W'(len), dlbp_pkg::LEN_W);
        append_field(dlbp_pkg::WORD_W'(d[dlbp_pkg::WORD_W-1]), 1);
        append_field(d, len);
        nbits = dlbp_pkg::TOTAL_W'(dlbp_pkg::HDR_W + len);
        if (acc_total > dlbp_pkg::TOTAL_MAX - nbits)
            acc_total = dlbp_pkg::TOTAL_MAX;
        else
            acc_total += nbits;
        if (req.end_of_stream) begin
            expect_word(acc_word, 1'b1, acc_total);
            start_stream();
        end
    endfunction

    function automatic void queue_request(logic [dlbp_pkg::WORD_W-1:0] s,
                                          logic [dlbp_pkg::WORD_W-1:0] p,
                                          logic eos);
        dlbp_pkg::t_in r;
        r.sample        = s;
        r.predicted     = p;
        r.end_of_stream = eos;
        sample_q.push_back(r);
    endfunction

    // Random prediction and a difference of exactly len magnitude bits
    function automatic void queue_delta(int unsigned len, bit neg, logic eos);
        logic [dlbp_pkg::WORD_W-1:0] mag;
        logic [dlbp_pkg::WORD_W-1:0] base;
        mag  = {$urandom, $urandom};
        base = {$urandom, $urandom};
        if (len == 0) begin
            mag = '0;
        end else begin
            mag &= (64'd1 << len) - 64'd1;
            mag[len-1] = 1'b1;
        end
        queue_request(base + (neg ? ~mag : mag), base, eos);
    endfunction

    // No idling on either side for a stretch in the middle of the run
    assign calm = (n_taken >= 110) && (n_taken < 190);

    always @(posedge i_clk) begin : drive_requests
        bit hold;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            hold = push && full;
            if (push && !full) begin
                pack_sample(sample_q.pop_front());
                n_taken++;
            end
            if (!hold) begin
                if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
                    push   <= 1'b1;
                    i_item <= sample_q[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        dlbp_pkg::t_out want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (packed_words_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word %h", o_result.packed_word));
                end else begin
                    want = packed_words_q.pop_front();
                    if (o_result.packed_word !== want.packed_word)
                        flag_mismatch($sformatf("packed_word %h, want %h",
                                      o_result.packed_word, want.packed_word));
                    if (o_result.final_word !== want.final_word)
                        flag_mismatch($sformatf("final_word %b, want %b",
                                      o_result.final_word, want.final_word));
                    if (o_result.bits_used !== want.bits_used)
                        flag_mismatch($sformatf("bits_used %0d, want %0d",
                                      o_result.bits_used, want.bits_used));
                    n_words++;
                    if (want.final_word)
                        n_final++;
                end
            end
            pop <= calm || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int unsigned len;
        start_stream();
        n_taken  = 0;
        n_words  = 0;
        n_final  = 0;
        n_errors = 0;
        quiet    = 0;

        // zero and minus-one differences, full-width and wrapping differences
        queue_request(64'd0, 64'd0, 1'b0);
        queue_request(64'd0, 64'd1, 1'b0);
        queue_request(64'h7fff_ffff_ffff_ffff, 64'd0, 1'b0);
        queue_request(64'h8000_0000_0000_0000, 64'd0, 1'b0);
        queue_request(64'h8000_0000_0000_0000, 64'd1, 1'b0);
        queue_request(64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0);
        queue_request(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 1'b0);
        queue_request(64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 1'b0);
        queue_request(64'd1, 64'd0, 1'b0);
        queue_request(64'hffff_ffff_ffff_fffe, 64'd0, 1'b0);
        queue_request(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1);
        // flush exactly on a word boundary, both signs
        queue_delta(25, 1'b0, 1'b1);
        queue_delta(25, 1'b1, 1'b1);
        // flush of a stream holding a single zero difference
        queue_request(64'd5, 64'd5, 1'b1);
        // fill to 58, then a full-width record crosses two boundaries
        queue_delta(19, 1'b0, 1'b0);
        queue_delta(63, 1'b1, 1'b1);
        // fill to 63, then a full-width record
        queue_delta(24, 1'b1, 1'b0);
        queue_delta(63, 1'b0, 1'b1);
        queue_delta(63, 1'b1, 1'b0);
        queue_delta(63, 1'b0, 1'b0);
        queue_delta(1, 1'b0, 1'b1);

        for (int k = 0; k < RANDOM_REQS; k++) begin
            len = $urandom_range(63);
            if ($urandom_range(99) < 20)
                queue_request({$urandom, $urandom}, {$urandom, $urandom},
                              ($urandom_range(11) == 0) || (k == RANDOM_REQS - 1));
            else
                queue_delta(len, 1'($urandom_range(1)),
                            ($urandom_range(11) == 0) || (k == RANDOM_REQS - 1));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_q.size() != 0 || push || packed_words_q.size() != 0)
            @(posedge i_clk);
        // hold a little longer to catch stray words
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d samples in %0d streams; %0d packed words checked",
                 n_taken, n_final, n_words);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
